/* hw/rtl/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants
// Permutation geometry, register indexes, sequencer states and the memory
// request bundle used by the RC4 stream cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

	localparam int PERM_SIZE = 256;
	localparam int IDX_W     = 8;
	localparam int KEY_REGS  = 4;
	localparam int KEY_W     = 64;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [LEN_W-1:0] KEY_LEN_RESET = 6'd8;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K0,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

/* hw/rtl/rc4_ram.sv */
// ----------------------------------------------------------------------------
// rc4_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the entry being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/rc4_cfg.sv */
// ----------------------------------------------------------------------------
// rc4_cfg: key and key length registers
// Holds the configured key words, clamps the key length and selects the
// key byte at the schedule's current key position.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_cfg #(
	parameter int MAX_KEY_BYTES = 32,
	parameter int NW            = $clog2(MAX_KEY_BYTES + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rc4_pkg::KEY_W-1:0]     cfg_wdata,
	input  wire logic [NW-1:0]                 key_pos,
	output logic      [NW-1:0]                 eff_len,
	output logic      [rc4_pkg::IDX_W-1:0]     key_byte
);

	logic [rc4_pkg::KEY_W-1:0] key_q [rc4_pkg::KEY_REGS];
	logic [rc4_pkg::LEN_W-1:0] len_q;
	logic [8:0]                len_w;
	logic [8:0]                pos_w;

	// capture register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rc4_pkg::KEY_REGS; r++) begin
				key_q[r] <= '0;
			end
			len_q <= rc4_pkg::KEY_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rc4_pkg::REG_KEY0:    key_q[0] <= cfg_wdata;
				rc4_pkg::REG_KEY1:    key_q[1] <= cfg_wdata;
				rc4_pkg::REG_KEY2:    key_q[2] <= cfg_wdata;
				rc4_pkg::REG_KEY3:    key_q[3] <= cfg_wdata;
				rc4_pkg::REG_KEY_LEN: len_q    <= cfg_wdata[rc4_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp length: zero means one, saturate at the key capacity
	always_comb begin
		len_w = 9'(len_q);
		if (len_w == 9'd0) begin
			len_w = 9'd1;
		end
		if (len_w > 9'(MAX_KEY_BYTES)) begin
			len_w = 9'(MAX_KEY_BYTES);
		end
		eff_len = NW'(len_w);
	end

	// select key byte; positions past the key registers read as zero
	always_comb begin
		pos_w = 9'(key_pos);
		if (pos_w < 9'd32) begin
			key_byte = key_q[pos_w[4:3]][{pos_w[2:0], 3'b000} +: 8];
		end else begin
			key_byte = '0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rc4_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit: RC4 keystream generator and combiner
// Sequencer around one permutation RAM; runs the key schedule on a message
// start and encrypts or decrypts one byte per input beat.
// ----------------------------------------------------------------------------
// A plain byte runs through states P0 to P3, the read, read, write/read, write
//   sequence on the single RAM read port, and waits in WAIT while output stalls.
// A message start (or the first byte after reset) first runs the key schedule:
//   an identity fill of all 256 entries plus 256 mixing steps of states K0 to K3.
// Input is ready only in IDLE: a new byte is taken once the last one is done.
// Reset: clears sequencer, indices, output valid and key words; length is 8.
`default_nettype none

module rc4_stream_cipher_unit #(
	parameter int MAX_KEY_BYTES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rc4_pkg::KEY_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          message_start,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [7:0]                    out_byte
);

	localparam int NW = $clog2(MAX_KEY_BYTES + 1);
	localparam int IW = rc4_pkg::IDX_W;

	rc4_pkg::state_t   state_q, state_d;
	rc4_pkg::ram_req_t ram_req;

	logic [IW-1:0] rdata;
	logic [IW-1:0] k_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] si_q;
	logic [IW-1:0] sj_q;
	logic [IW-1:0] t_q;
	logic [7:0]    data_q;
	logic [NW-1:0] kpos_q;
	logic          scheduled_q;
	logic [7:0]    out_byte_q;
	logic          out_valid_q;

	logic [NW-1:0] eff_len;
	logic [IW-1:0] key_byte;
	logic [IW-1:0] j_ksa;
	logic [IW-1:0] j_prga;
	logic [IW-1:0] i_next;
	logic [IW-1:0] t_next;
	logic [IW-1:0] ks;
	logic [8:0]    kpos_inc;
	logic          out_free;
	logic          in_beat;
	logic          byte_done;

	rc4_cfg #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES),
		.NW           (NW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.key_pos  (kpos_q),
		.eff_len  (eff_len),
		.key_byte (key_byte)
	);

	rc4_ram #(
		.WIDTH(IW),
		.DEPTH(rc4_pkg::PERM_SIZE)
	) u_perm (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(rdata)
	);

	// datapath helpers
	assign in_ready  = (state_q == rc4_pkg::ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign byte_done = ((state_q == rc4_pkg::ST_P3) || (state_q == rc4_pkg::ST_WAIT))
		&& out_free;
	assign j_ksa     = j_q + rdata + key_byte;
	assign j_prga    = j_q + rdata;
	assign i_next    = i_q + 8'd1;
	assign t_next    = si_q + rdata;
	assign kpos_inc  = 9'(kpos_q) + 9'd1;

	// keystream byte after the swap: forward the swapped entries
	always_comb begin
		if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = rdata;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM requests
	always_comb begin
		state_d       = state_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = k_q;
		ram_req.wdata = k_q;
		ram_req.raddr = k_q;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				if (in_beat) begin
					if (message_start || !scheduled_q) begin
						state_d = rc4_pkg::ST_INIT;
					end else begin
						state_d = rc4_pkg::ST_P0;
					end
				end
			end
			rc4_pkg::ST_INIT: begin
				ram_req.we = 1'b1;
				if (k_q == 8'hFF) begin
					state_d = rc4_pkg::ST_K0;
				end
			end
			rc4_pkg::ST_K0: begin
				state_d = rc4_pkg::ST_K1;
			end
			rc4_pkg::ST_K1: begin
				ram_req.raddr = j_ksa;
				state_d       = rc4_pkg::ST_K2;
			end
			rc4_pkg::ST_K2: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = rdata;
				state_d       = rc4_pkg::ST_K3;
			end
			rc4_pkg::ST_K3: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = j_q;
				ram_req.wdata = si_q;
				if (k_q == 8'hFF) begin
					state_d = rc4_pkg::ST_P0;
				end else begin
					state_d = rc4_pkg::ST_K0;
				end
			end
			rc4_pkg::ST_P0: begin
				ram_req.raddr = i_next;
				state_d       = rc4_pkg::ST_P1;
			end
			rc4_pkg::ST_P1: begin
				ram_req.raddr = j_prga;
				state_d       = rc4_pkg::ST_P2;
			end
			rc4_pkg::ST_P2: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = i_q;
				ram_req.wdata = rdata;
				ram_req.raddr = t_next;
				state_d       = rc4_pkg::ST_P3;
			end
			rc4_pkg::ST_P3: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = j_q;
				ram_req.wdata = si_q;
				if (out_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end else begin
					state_d = rc4_pkg::ST_WAIT;
				end
			end
			rc4_pkg::ST_WAIT: begin
				if (out_free) begin
					state_d = rc4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rc4_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers: indices, schedule flag, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			kpos_q      <= '0;
			scheduled_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a finished byte, drop once taken
			if (byte_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (in_beat && (message_start || !scheduled_q)) begin
						k_q <= '0;
					end
				end
				rc4_pkg::ST_INIT: begin
					k_q <= k_q + 8'd1;
					if (k_q == 8'hFF) begin
						j_q    <= '0;
						kpos_q <= '0;
					end
				end
				rc4_pkg::ST_K1: begin
					j_q <= j_ksa;
				end
				rc4_pkg::ST_K3: begin
					k_q <= k_q + 8'd1;
					if (kpos_inc == 9'(eff_len)) begin
						kpos_q <= '0;
					end else begin
						kpos_q <= NW'(kpos_inc);
					end
					if (k_q == 8'hFF) begin
						i_q         <= '0;
						j_q         <= '0;
						scheduled_q <= 1'b1;
					end
				end
				rc4_pkg::ST_P0: begin
					i_q <= i_next;
				end
				rc4_pkg::ST_P1: begin
					j_q <= j_prga;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			data_q <= in_byte;
		end
		case (state_q)
			rc4_pkg::ST_K1, rc4_pkg::ST_P1: begin
				si_q <= rdata;
			end
			rc4_pkg::ST_P2: begin
				sj_q <= rdata;
				t_q  <= t_next;
			end
			rc4_pkg::ST_P3: begin
				if (out_free) begin
					out_byte_q <= data_q ^ ks;
				end else begin
					data_q <= data_q ^ ks;
				end
			end
			rc4_pkg::ST_WAIT: begin
				if (out_free) begin
					out_byte_q <= data_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

`default_nettype wire

/* hw/rtl/rc4_checker.sv */
// ----------------------------------------------------------------------------
// rc4_checker: port-level checks for the RC4 stream cipher unit
// Watches the handshakes over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte
);

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("stalled output beat changed");

	// a taken byte keeps the input not ready through the P0 to P3 sequence
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken again before the byte finished");

	// a new output beat appears only out of a busy cycle
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("output beat without work in flight");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_byte (out_byte)
);

`default_nettype wire
